// ----- design/binary_contour_tracer_macros.svh -----
// ----------------------------------------------------------------------------
// Binary contour tracer assertion macros
// Shared property shapes for the port checker of the contour tracer.
// ----------------------------------------------------------------------------
`ifndef BINARY_CONTOUR_TRACER_MACROS_SVH
`define BINARY_CONTOUR_TRACER_MACROS_SVH

// Same-cycle implication, switched off while reset is held
`define BCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held
`define BCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bct_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary contour tracer package
// Shared widths, codes, probe tables and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bct_pkg;

    // Default sizes handed down from the top level
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_STEPS  = 131072;

    // Port widths
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int COORD_W     = 8;

    // Operation codes carried in s_tuser
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT     = 2'd2;

    // Result status codes carried in m_tuser
    localparam logic [M_TUSER_W-1:0] ST_POINT = 2'd0;
    localparam logic [M_TUSER_W-1:0] ST_LAST  = 2'd1;
    localparam logic [M_TUSER_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [M_TUSER_W-1:0] ST_LIMIT = 2'd3;

    // Headings: north is +y, east is +x
    typedef enum logic [1:0] {
        HEAD_NORTH = 2'd0,
        HEAD_SOUTH = 2'd1,
        HEAD_EAST  = 2'd2,
        HEAD_WEST  = 2'd3
    } heading_t;

    // Neighbour offset, two's complement in two bits
    typedef logic [1:0] offset_t;
    localparam offset_t OFF_NEG  = 2'b11;
    localparam offset_t OFF_ZERO = 2'b00;
    localparam offset_t OFF_POS  = 2'b01;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                 mem_we;
        logic                 rd_scan;
        offset_t              off_dx;
        offset_t              off_dy;
        logic                 scan_clr;
        logic                 scan_inc;
        logic                 load_start;
        logic                 take_probe;
        logic                 restore_start;
        logic                 heading_load;
        heading_t             heading_val;
        logic                 step_inc;
        logic                 out_load;
        logic                 out_zero;
        logic [M_TUSER_W-1:0] out_status;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic     hit;
        logic     scan_last;
        logic     cur_x_zero;
        logic     width_gt1;
        logic     cur_y_gt1;
        logic     cur_y_lt_hm1;
        logic     at_start;
        logic     step_limit;
        logic     out_free;
        heading_t heading;
    } dp_status_t;

    // Column offset of probe i (front-left, front, front-right) for heading h
    function automatic offset_t probe_dx(heading_t h, logic [1:0] i);
        offset_t d;
        unique case (h)
            HEAD_NORTH: d = (i == 2'd0) ? OFF_NEG : ((i == 2'd1) ? OFF_ZERO : OFF_POS);
            HEAD_SOUTH: d = (i == 2'd0) ? OFF_POS : ((i == 2'd1) ? OFF_ZERO : OFF_NEG);
            HEAD_EAST:  d = OFF_POS;
            HEAD_WEST:  d = OFF_NEG;
            default:    d = OFF_ZERO;
        endcase
        return d;
    endfunction

    // Row offset of probe i for heading h
    function automatic offset_t probe_dy(heading_t h, logic [1:0] i);
        offset_t d;
        unique case (h)
            HEAD_NORTH: d = OFF_POS;
            HEAD_SOUTH: d = OFF_NEG;
            HEAD_EAST:  d = (i == 2'd0) ? OFF_POS : ((i == 2'd1) ? OFF_ZERO : OFF_NEG);
            HEAD_WEST:  d = (i == 2'd0) ? OFF_NEG : ((i == 2'd1) ? OFF_ZERO : OFF_POS);
            default:    d = OFF_ZERO;
        endcase
        return d;
    endfunction

    // New heading after a hit on probe i
    function automatic heading_t turn_to(heading_t h, logic [1:0] i);
        heading_t n;
        unique case (h)
            HEAD_NORTH: n = (i == 2'd0) ? HEAD_WEST  : HEAD_NORTH;
            HEAD_SOUTH: n = (i == 2'd0) ? HEAD_EAST  : HEAD_SOUTH;
            HEAD_EAST:  n = (i == 2'd0) ? HEAD_NORTH : HEAD_EAST;
            HEAD_WEST:  n = (i == 2'd0) ? HEAD_SOUTH : HEAD_WEST;
            default:    n = HEAD_NORTH;
        endcase
        return n;
    endfunction

    // Quarter turn clockwise
    function automatic heading_t rotate_cw(heading_t h);
        heading_t n;
        unique case (h)
            HEAD_NORTH: n = HEAD_EAST;
            HEAD_SOUTH: n = HEAD_WEST;
            HEAD_EAST:  n = HEAD_SOUTH;
            HEAD_WEST:  n = HEAD_NORTH;
            default:    n = HEAD_NORTH;
        endcase
        return n;
    endfunction

    // Column offset of the k-th of the eight neighbours
    function automatic offset_t ring_dx(logic [2:0] k);
        offset_t d;
        unique case (k)
            3'd0, 3'd3, 3'd5: d = OFF_NEG;
            3'd1, 3'd6:       d = OFF_ZERO;
            default:          d = OFF_POS;
        endcase
        return d;
    endfunction

    // Row offset of the k-th of the eight neighbours
    function automatic offset_t ring_dy(logic [2:0] k);
        offset_t d;
        unique case (k)
            3'd0, 3'd1, 3'd2: d = OFF_NEG;
            3'd3, 3'd4:       d = OFF_ZERO;
            default:          d = OFF_POS;
        endcase
        return d;
    endfunction

endpackage

// ----- design/bct_ctrl.sv -----
// ----------------------------------------------------------------------------
// Contour tracer controller
// Sequences pixel writes, the start scan, the start heading and isolation
// checks, the probe walk of each step and the hand-off of each result.
// ----------------------------------------------------------------------------
module bct_ctrl
    import bct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       op,
    output dp_cmd_t    cmd,
    input  dp_status_t stat
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_SCAN_RD  = 11'b00000000010,
        S_SCAN_CHK = 11'b00000000100,
        S_HEAD_SEL = 11'b00000001000,
        S_HEAD_CHK = 11'b00000010000,
        S_ISO_RD   = 11'b00000100000,
        S_ISO_CHK  = 11'b00001000000,
        S_ADV_RD   = 11'b00010000000,
        S_ADV_CHK  = 11'b00100000000,
        S_ADV_END  = 11'b01000000000,
        S_EMIT     = 11'b10000000000
    } state_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_TRACE = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    state_t               state_reg,  state_next;
    phase_t               phase_reg,  phase_next;
    logic [1:0]           probe_reg,  probe_next;
    logic [1:0]           turn_reg,   turn_next;
    logic [2:0]           ring_reg,   ring_next;
    heading_t             cand_reg,   cand_next;
    logic [M_TUSER_W-1:0] pend_reg,   pend_next;
    logic                 zero_reg,   zero_next;

    logic accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        probe_next = probe_reg;
        turn_next  = turn_reg;
        ring_next  = ring_reg;
        cand_next  = cand_reg;
        pend_next  = pend_reg;
        zero_next  = zero_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (op == OP_WRITE) begin
                        cmd.mem_we = 1'b1;
                        phase_next = PH_START;
                    end else begin
                        unique case (phase_reg)
                            PH_START: begin
                                cmd.scan_clr = 1'b1;
                                state_next   = S_SCAN_RD;
                            end
                            PH_TRACE: begin
                                if (stat.step_limit) begin
                                    pend_next  = ST_LIMIT;
                                    zero_next  = 1'b0;
                                    phase_next = PH_DONE;
                                    state_next = S_EMIT;
                                end else begin
                                    probe_next = 2'd0;
                                    turn_next  = 2'd0;
                                    state_next = S_ADV_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            S_SCAN_RD: begin
                cmd.rd_scan = 1'b1;
                state_next  = S_SCAN_CHK;
            end

            S_SCAN_CHK: begin
                if (stat.hit) begin
                    cmd.load_start = 1'b1;
                    state_next     = S_HEAD_SEL;
                end else if (stat.scan_last) begin
                    pend_next  = ST_EMPTY;
                    zero_next  = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end

            // Pick the one neighbour that decides the start heading
            S_HEAD_SEL: begin
                ring_next = 3'd0;
                priority if (!stat.cur_x_zero) begin
                    state_next = S_ISO_RD;
                end else if (stat.width_gt1) begin
                    cmd.off_dx = OFF_POS;
                    cmd.off_dy = OFF_ZERO;
                    cand_next  = HEAD_SOUTH;
                    state_next = S_HEAD_CHK;
                end else if (stat.cur_y_gt1) begin
                    cmd.off_dx = OFF_ZERO;
                    cmd.off_dy = OFF_NEG;
                    cand_next  = HEAD_WEST;
                    state_next = S_HEAD_CHK;
                end else if (stat.cur_y_lt_hm1) begin
                    cmd.off_dx = OFF_ZERO;
                    cmd.off_dy = OFF_POS;
                    cand_next  = HEAD_EAST;
                    state_next = S_HEAD_CHK;
                end else begin
                    state_next = S_ISO_RD;
                end
            end

            S_HEAD_CHK: begin
                if (!stat.hit) begin
                    cmd.heading_load = 1'b1;
                    cmd.heading_val  = cand_reg;
                end
                state_next = S_ISO_RD;
            end

            // Walk the eight neighbours of the start point
            S_ISO_RD: begin
                cmd.off_dx = ring_dx(ring_reg);
                cmd.off_dy = ring_dy(ring_reg);
                state_next = S_ISO_CHK;
            end

            S_ISO_CHK: begin
                priority if (stat.hit) begin
                    pend_next  = ST_POINT;
                    zero_next  = 1'b0;
                    phase_next = PH_TRACE;
                    state_next = S_EMIT;
                end else if (ring_reg == 3'd7) begin
                    pend_next  = ST_LAST;
                    zero_next  = 1'b0;
                    phase_next = PH_DONE;
                    state_next = S_EMIT;
                end else begin
                    ring_next  = ring_reg + 3'd1;
                    state_next = S_ISO_RD;
                end
            end

            // Probe front-left, front, front-right, then rotate
            S_ADV_RD: begin
                cmd.off_dx = probe_dx(stat.heading, probe_reg);
                cmd.off_dy = probe_dy(stat.heading, probe_reg);
                state_next = S_ADV_CHK;
            end

            S_ADV_CHK: begin
                priority if (stat.hit) begin
                    cmd.take_probe   = 1'b1;
                    cmd.heading_load = 1'b1;
                    cmd.heading_val  = turn_to(stat.heading, probe_reg);
                    state_next       = S_ADV_END;
                end else if (probe_reg != 2'd2) begin
                    probe_next = probe_reg + 2'd1;
                    state_next = S_ADV_RD;
                end else if (turn_reg != 2'd3) begin
                    turn_next        = turn_reg + 2'd1;
                    probe_next       = 2'd0;
                    cmd.heading_load = 1'b1;
                    cmd.heading_val  = rotate_cw(stat.heading);
                    state_next       = S_ADV_RD;
                end else begin
                    cmd.restore_start = 1'b1;
                    state_next        = S_ADV_END;
                end
            end

            S_ADV_END: begin
                cmd.step_inc = 1'b1;
                zero_next    = 1'b0;
                if (stat.at_start) begin
                    pend_next  = ST_LAST;
                    phase_next = PH_DONE;
                end else begin
                    pend_next  = ST_POINT;
                end
                state_next = S_EMIT;
            end

            // Hold the result until the output register is free
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_zero   = zero_reg;
                    cmd.out_status = pend_reg;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_START;
            probe_reg <= 2'd0;
            turn_reg  <= 2'd0;
            ring_reg  <= 3'd0;
            cand_reg  <= HEAD_NORTH;
            pend_reg  <= ST_POINT;
            zero_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            probe_reg <= probe_next;
            turn_reg  <= turn_next;
            ring_reg  <= ring_next;
            cand_reg  <= cand_next;
            pend_reg  <= pend_next;
            zero_reg  <= zero_next;
        end
    end

endmodule

// ----- design/bct_datapath.sv -----
// ----------------------------------------------------------------------------
// Contour tracer datapath
// Configuration registers, pixel bit memory, scan counters, probe address
// unit, trace position and heading, step counter and result register.
// ----------------------------------------------------------------------------
module bct_datapath
    import bct_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_STEPS  = DEF_MAX_STEPS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  dp_cmd_t                cmd,
    output dp_status_t             stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic [M_TUSER_W-1:0]   m_tuser
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int EXW   = $clog2(MAX_WIDTH + 1);
    localparam int EYW   = $clog2(MAX_HEIGHT + 1);
    localparam int CXW   = (EXW > CFG_DATA_W) ? EXW : CFG_DATA_W;
    localparam int CYW   = (EYW > CFG_DATA_W) ? EYW : CFG_DATA_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_STEPS + 1);
    localparam int OXW   = (XW > COORD_W) ? XW : COORD_W;
    localparam int OYW   = (YW > COORD_W) ? YW : COORD_W;

    // Configuration registers
    logic                  fg_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    // Trace state
    logic [XW-1:0] scan_x_reg, cur_x_reg, start_x_reg, probe_x_reg;
    logic [YW-1:0] scan_y_reg, cur_y_reg, start_y_reg, probe_y_reg;
    heading_t      heading_reg;
    logic [SW-1:0] step_reg;
    logic          probe_ok_reg;
    logic          rd_bit_reg;

    // Result register
    logic                 out_valid_reg;
    logic [COORD_W-1:0]   out_x_reg, out_y_reg;
    logic [M_TUSER_W-1:0] out_status_reg;

    // Pixel memory, one bit per pixel
    logic mem [DEPTH];

    logic [CXW-1:0] w_wide, w_sat;
    logic [CYW-1:0] h_wide, h_sat;
    logic [EXW-1:0] eff_w;
    logic [EYW-1:0] eff_h;

    logic [COORD_W-1:0] wr_x, wr_y;
    logic               wr_in_range;
    logic [AW-1:0]      wr_addr, rd_addr;

    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic [XW+1:0]        nx_u, ext_w;
    logic [YW+1:0]        ny_u, ext_h;
    logic                 n_ok, rd_ok;
    logic [XW-1:0]        rd_x;
    logic [YW-1:0]        rd_y;
    logic                 scan_x_last, scan_y_last;

    logic [OXW-1:0] cur_x_wide;
    logic [OYW-1:0] cur_y_wide;

    // Clamp the size registers: zero counts as one, large values saturate
    always_comb begin
        w_wide = CXW'(width_reg);
        h_wide = CYW'(height_reg);
        if (width_reg == '0) begin
            w_sat = CXW'(1);
        end else if (w_wide > CXW'(MAX_WIDTH)) begin
            w_sat = CXW'(MAX_WIDTH);
        end else begin
            w_sat = w_wide;
        end
        if (height_reg == '0) begin
            h_sat = CYW'(1);
        end else if (h_wide > CYW'(MAX_HEIGHT)) begin
            h_sat = CYW'(MAX_HEIGHT);
        end else begin
            h_sat = h_wide;
        end
    end

    assign eff_w = w_sat[EXW-1:0];
    assign eff_h = h_sat[EYW-1:0];

    // Pixel write address, writes outside the store are dropped
    assign wr_x        = s_tdata[COORD_W-1:0];
    assign wr_y        = s_tdata[2*COORD_W-1:COORD_W];
    assign wr_in_range = (32'(wr_x) < 32'(MAX_WIDTH)) && (32'(wr_y) < 32'(MAX_HEIGHT));
    assign wr_addr     = AW'(wr_y) * AW'(MAX_WIDTH) + AW'(wr_x);

    // Neighbour of the current point and its bounds check
    assign nx    = $signed({2'b00, cur_x_reg}) + $signed({{XW{cmd.off_dx[1]}}, cmd.off_dx});
    assign ny    = $signed({2'b00, cur_y_reg}) + $signed({{YW{cmd.off_dy[1]}}, cmd.off_dy});
    assign nx_u  = nx;
    assign ny_u  = ny;
    assign ext_w = (XW + 2)'(eff_w);
    assign ext_h = (YW + 2)'(eff_h);
    assign n_ok  = !nx_u[XW+1] && !ny_u[YW+1] && (nx_u < ext_w) && (ny_u < ext_h);

    // Read address: scan position or probed neighbour
    always_comb begin
        if (cmd.rd_scan) begin
            rd_x  = scan_x_reg;
            rd_y  = scan_y_reg;
            rd_ok = 1'b1;
        end else begin
            rd_x  = nx_u[XW-1:0];
            rd_y  = ny_u[YW-1:0];
            rd_ok = n_ok;
        end
    end

    assign rd_addr = AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x);

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.mem_we && wr_in_range) begin
            mem[wr_addr] <= s_tdata[2*COORD_W];
        end
        rd_bit_reg <= mem[rd_addr];
    end

    // Keep the coordinates and bounds flag of the pixel being read
    always_ff @(posedge aclk) begin
        probe_x_reg  <= rd_x;
        probe_y_reg  <= rd_y;
        probe_ok_reg <= rd_ok;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg     <= 1'b0;
            width_reg  <= CFG_DATA_W'(256);
            height_reg <= CFG_DATA_W'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FOREGROUND: fg_reg     <= cfg_wdata[0];
                CFG_WIDTH:      width_reg  <= cfg_wdata;
                CFG_HEIGHT:     height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Raster scan counters
    assign scan_x_last = (EXW'(scan_x_reg) == eff_w - EXW'(1));
    assign scan_y_last = (EYW'(scan_y_reg) == eff_h - EYW'(1));

    always_ff @(posedge aclk) begin
        if (cmd.scan_clr) begin
            scan_x_reg <= '0;
            scan_y_reg <= '0;
        end else if (cmd.scan_inc) begin
            if (scan_x_last) begin
                scan_x_reg <= '0;
                scan_y_reg <= scan_y_reg + YW'(1);
            end else begin
                scan_x_reg <= scan_x_reg + XW'(1);
            end
        end
    end

    // Trace position, start point, heading and step count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            heading_reg <= HEAD_NORTH;
            step_reg    <= '0;
        end else begin
            if (cmd.load_start) begin
                cur_x_reg   <= probe_x_reg;
                cur_y_reg   <= probe_y_reg;
                start_x_reg <= probe_x_reg;
                start_y_reg <= probe_y_reg;
                step_reg    <= '0;
            end else if (cmd.take_probe) begin
                cur_x_reg <= probe_x_reg;
                cur_y_reg <= probe_y_reg;
            end else if (cmd.restore_start) begin
                cur_x_reg <= start_x_reg;
                cur_y_reg <= start_y_reg;
            end
            if (cmd.load_start) begin
                heading_reg <= HEAD_NORTH;
            end else if (cmd.heading_load) begin
                heading_reg <= cmd.heading_val;
            end
            if (cmd.step_inc) begin
                step_reg <= step_reg + SW'(1);
            end
        end
    end

    // Result register, reloaded as the waiting item is taken
    assign cur_x_wide = OXW'(cur_x_reg);
    assign cur_y_wide = OYW'(cur_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_x_reg      <= cmd.out_zero ? '0 : cur_x_wide[COORD_W-1:0];
            out_y_reg      <= cmd.out_zero ? '0 : cur_y_wide[COORD_W-1:0];
            out_status_reg <= cmd.out_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = out_status_reg;

    // Status to the controller
    assign stat.hit          = probe_ok_reg && (rd_bit_reg == fg_reg);
    assign stat.scan_last    = scan_x_last && scan_y_last;
    assign stat.cur_x_zero   = (cur_x_reg == '0);
    assign stat.width_gt1    = (eff_w > EXW'(1));
    assign stat.cur_y_gt1    = (cur_y_reg > YW'(1));
    assign stat.cur_y_lt_hm1 = (EYW'(cur_y_reg) < eff_h - EYW'(1));
    assign stat.at_start     = (cur_x_reg == start_x_reg) && (cur_y_reg == start_y_reg);
    assign stat.step_limit   = (step_reg >= SW'(MAX_STEPS));
    assign stat.out_free     = !out_valid_reg || m_tready;
    assign stat.heading      = heading_reg;

endmodule

// ----- design/binary_contour_tracer.sv -----
// ----------------------------------------------------------------------------
// Binary contour tracer
// Loads a binary image pixel by pixel and returns its outer contour one
// point per request.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  tuser operation, tdata pixel x/y/value
//   m_       out  m_tvalid/m_tready  tuser status, tdata point x/y
//   cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
// A step request makes up to twelve neighbour probes, each a registered
// read of the pixel memory, and none when the step limit is hit. The
// first request after a write also scans the image pixel by pixel, then
// checks up to nine neighbours.
// The result waits in an output register; a stalled m_tready blocks only
// the next request that has a result ready. Reset is synchronous; the
// pixel memory is not cleared.
// ----------------------------------------------------------------------------
module binary_contour_tracer
    import bct_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_STEPS  = DEF_MAX_STEPS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // pixel_x[7:0], pixel_y[15:8], pixel_value[16]
    input  logic                   s_tuser,   // operation[0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // point_x[7:0], point_y[15:8]
    output logic [M_TUSER_W-1:0]   m_tuser,   // status[1:0]
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    // Sequencer
    bct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Storage and arithmetic
    bct_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_STEPS  (MAX_STEPS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- design/bct_checker.sv -----
// ----------------------------------------------------------------------------
// Contour tracer port checker
// Watches the top-level ports for result hold, empty-image results and
// input readiness after pixel writes.
// ----------------------------------------------------------------------------
`include "binary_contour_tracer_macros.svh"

module bct_checker
    import bct_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A waiting result holds until taken
    `BCT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

    // An empty image reports the origin
    `BCT_ASSERT_IMPLY(a_empty_origin, aclk, aresetn, m_tvalid && (m_tuser == ST_EMPTY), m_tdata == '0, "empty-image result with non-zero point")

    // A pixel write leaves the input ready for the next item
    `BCT_ASSERT_NEXT(a_write_ready, aclk, aresetn, s_tvalid && s_tready && (s_tuser == OP_WRITE), s_tready, "input not ready after a pixel write")

endmodule

bind binary_contour_tracer bct_checker u_bct_checker (.*);
